// ===== rtl/mtg_pkg.sv =====
// Shared constants, types and helpers for the MT19937 generator.
// No dependencies; mtg_seed, mtg_twist and the top level refer to this package by scoped names.
package mtg_pkg;

  localparam int unsigned StateLength = 624;
  localparam int unsigned AddrW       = $clog2(StateLength);
  localparam int unsigned WordW       = 32;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [WordW-1:0] word_t;

  localparam addr_t TwistOffset = addr_t'(397);

  localparam word_t MatrixA     = 32'h9908_b0df;
  localparam word_t TemperB     = 32'h9d2c_5680;
  localparam word_t TemperC     = 32'hefc6_0000;
  localparam word_t HighBit     = 32'h8000_0000;
  localparam word_t LowBits     = 32'h7fff_ffff;
  localparam word_t SeedMult    = 32'd6069;
  localparam word_t DefaultSeed = 32'd4357;

  // Request codes carried on the action field
  typedef enum logic {
    ActReseed = 1'b0,
    ActDraw   = 1'b1
  } action_e;

  // Control states of the top level
  typedef enum logic [1:0] {
    StRun  = 2'b01,
    StSeed = 2'b10
  } state_e;

  // Write port request from the seed filler
  typedef struct packed {
    logic  we;
    addr_t addr;
    word_t data;
    logic  last;
  } seed_wr_t;

  // Add two in-range indexes modulo the state length
  function automatic addr_t wrap_add(addr_t a, addr_t b);
    logic [AddrW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (AddrW + 1)'(StateLength)) begin
      sum = sum - (AddrW + 1)'(StateLength);
    end
    return sum[AddrW-1:0];
  endfunction

endpackage

// ===== rtl/mtg_ram.sv =====
// Generic synchronous RAM: one write port, two read ports, registered read data.
// Standalone; no package dependencies.
module mtg_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 624,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [Width-1:0] rdata_a_o,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read two entries; hold the data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== rtl/mtg_seed.sv =====
// Seed filler: sweeps the state memory with w[0] = seed, w[i] = 6069 * w[i-1].
// Depends on mtg_pkg.
module mtg_seed (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  mtg_pkg::word_t   seed_i,
  output mtg_pkg::seed_wr_t wr_o
);

  logic           busy_q, busy_d;
  mtg_pkg::addr_t cnt_q, cnt_d;
  mtg_pkg::word_t val_q, val_d;
  logic           last;

  assign last = (cnt_q == mtg_pkg::addr_t'(mtg_pkg::StateLength - 1));

  // Advance the sweep one entry per cycle
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    val_d  = val_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      val_d  = seed_i;
    end else if (busy_q) begin
      busy_d = !last;
      cnt_d  = cnt_q + mtg_pkg::addr_t'(1);
      val_d  = mtg_pkg::word_t'(val_q * mtg_pkg::SeedMult);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  // Drive the memory write request
  assign wr_o.we   = busy_q;
  assign wr_o.addr = cnt_q;
  assign wr_o.data = val_q;
  assign wr_o.last = busy_q && last;

endmodule

// ===== rtl/mtg_twist.sv =====
// Twist and temper datapath: one new state word and its tempered output.
// Depends on mtg_pkg.
module mtg_twist (
  input  mtg_pkg::word_t cur_i,
  input  mtg_pkg::word_t nxt_i,
  input  mtg_pkg::word_t far_i,
  output mtg_pkg::word_t new_o,
  output mtg_pkg::word_t tempered_o
);

  mtg_pkg::word_t y;
  mtg_pkg::word_t v;
  mtg_pkg::word_t t0, t1, t2;

  // Combine high bit of the current word with low bits of the next one
  always_comb begin
    y = (cur_i & mtg_pkg::HighBit) | (nxt_i & mtg_pkg::LowBits);
    v = far_i ^ (y >> 1);
    if (y[0]) begin
      v = v ^ mtg_pkg::MatrixA;
    end
  end

  // Temper the new word
  always_comb begin
    t0 = v ^ (v >> 11);
    t1 = t0 ^ ((t0 << 7) & mtg_pkg::TemperB);
    t2 = t1 ^ ((t1 << 15) & mtg_pkg::TemperC);
  end

  assign new_o      = v;
  assign tempered_o = t2 ^ (t2 >> 18);

endmodule

// ===== rtl/mersenne_twister_generator.sv =====
// MT19937 generator top level: control, state memory, twist datapath, output register.
// A draw's word appears the cycle after acceptance; one draw per cycle while output is taken.
// A reseed request holds input ready low while the seed filler sweeps memory.
// The first draw after reset triggers the same fill with seed 4357 first.
// Reset clears control state and marks the block unseeded; the state memory is not cleared.
// Depends on mtg_pkg, mtg_ram, mtg_seed and mtg_twist.
module mersenne_twister_generator (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  logic  action_i,
  input  logic [31:0] seed_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output logic [31:0] word_o
);

  mtg_pkg::state_e   state_q, state_d;
  logic              unseeded_q, unseeded_d;
  mtg_pkg::addr_t    k_q, k_d;
  mtg_pkg::word_t    cur_q, cur_d;
  logic              out_valid_q, out_valid_d;
  mtg_pkg::word_t    word_q, word_d;

  mtg_pkg::seed_wr_t seed_wr;
  logic              seed_start;
  mtg_pkg::word_t    seed_val;

  logic              is_draw;
  logic              draw_ok;
  logic              accept;
  logic              draw_fire;
  mtg_pkg::addr_t    k_next;

  logic              ram_we;
  mtg_pkg::addr_t    ram_waddr;
  mtg_pkg::word_t    ram_wdata;
  logic              ram_re;
  mtg_pkg::addr_t    ram_raddr_a;
  mtg_pkg::addr_t    ram_raddr_b;
  mtg_pkg::word_t    ram_rdata_a;
  mtg_pkg::word_t    ram_rdata_b;

  mtg_pkg::word_t    twist_new;
  mtg_pkg::word_t    twist_out;

  // Request handshake
  assign is_draw    = (action_i == mtg_pkg::ActDraw);
  assign draw_ok    = !unseeded_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = (state_q == mtg_pkg::StRun) && (!is_draw || draw_ok);
  assign accept     = in_valid_i && in_ready_o;
  assign draw_fire  = accept && is_draw;

  // Start a fill on a reseed, or on a draw that finds the block unseeded
  assign seed_start = (state_q == mtg_pkg::StRun) &&
                      ((accept && !is_draw) || (in_valid_i && is_draw && unseeded_q));
  assign seed_val   = is_draw ? mtg_pkg::DefaultSeed : seed_i;

  assign k_next = mtg_pkg::wrap_add(k_q, mtg_pkg::addr_t'(1));

  // Control state and cursor
  always_comb begin
    state_d    = state_q;
    unseeded_d = unseeded_q;
    k_d        = k_q;
    cur_d      = cur_q;
    unique case (state_q)
      mtg_pkg::StRun: begin
        if (seed_start) begin
          state_d    = mtg_pkg::StSeed;
          unseeded_d = 1'b0;
          k_d        = '0;
          cur_d      = seed_val;
        end else if (draw_fire) begin
          k_d   = k_next;
          cur_d = ram_rdata_a;
        end
      end
      mtg_pkg::StSeed: begin
        if (seed_wr.last) begin
          state_d = mtg_pkg::StRun;
        end
      end
      default: begin
        state_d = mtg_pkg::StRun;
      end
    endcase
  end

  // Output register: load on a draw, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    word_d      = word_q;
    if (draw_fire) begin
      out_valid_d = 1'b1;
      word_d      = twist_out;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mtg_pkg::StRun;
      unseeded_q  <= 1'b1;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      unseeded_q  <= unseeded_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    word_q <= word_d;
  end

  // Memory access: fill writes during a sweep, twisted word on a draw.
  // Reads fetch the next and far words for the following index; they never
  // hit the entry written in the same cycle.
  always_comb begin
    if (state_q == mtg_pkg::StSeed) begin
      ram_we    = seed_wr.we;
      ram_waddr = seed_wr.addr;
      ram_wdata = seed_wr.data;
    end else begin
      ram_we    = draw_fire;
      ram_waddr = k_q;
      ram_wdata = twist_new;
    end
    if (state_q == mtg_pkg::StSeed) begin
      ram_re      = seed_wr.last;
      ram_raddr_a = mtg_pkg::addr_t'(1);
      ram_raddr_b = mtg_pkg::TwistOffset;
    end else begin
      ram_re      = draw_fire;
      ram_raddr_a = mtg_pkg::wrap_add(k_q, mtg_pkg::addr_t'(2));
      ram_raddr_b = mtg_pkg::wrap_add(k_next, mtg_pkg::TwistOffset);
    end
  end

  mtg_seed u_seed (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (seed_start),
    .seed_i  (seed_val),
    .wr_o    (seed_wr)
  );

  mtg_ram #(
    .Width (mtg_pkg::WordW),
    .Depth (mtg_pkg::StateLength)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_i      (ram_re),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_a_o (ram_rdata_a),
    .rdata_b_o (ram_rdata_b)
  );

  mtg_twist u_twist (
    .cur_i      (cur_q),
    .nxt_i      (ram_rdata_a),
    .far_i      (ram_rdata_b),
    .new_o      (twist_new),
    .tempered_o (twist_out)
  );

  assign out_valid_o = out_valid_q;
  assign word_o      = word_q;

endmodule

// ===== rtl/mtg_checker.sv =====
// Port-level checker for the MT19937 generator, bound to the top level.
// Depends only on the top level's ports.
module mtg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        action_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] word_o
);

  logic reseed_acc;
  logic draw_acc;

  assign reseed_acc = in_valid_i && in_ready_o && !action_i;
  assign draw_acc   = in_valid_i && in_ready_o && action_i;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(word_o))
    else $error("stalled result changed or dropped");

  // Every accepted draw shows a result in the next cycle
  a_draw_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    draw_acc |=> out_valid_o)
    else $error("accepted draw gave no result");

  // No draw is taken while the output slot is blocked
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !draw_acc)
    else $error("draw accepted over a blocked result");

  // A reseed occupies the block at the start of the state fill
  a_reseed_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reseed_acc |=> !in_ready_o ##1 !in_ready_o)
    else $error("request taken during state fill");

endmodule

bind mersenne_twister_generator mtg_checker u_mtg_checker (.*);
